// ===== rtl/olrd_pkg.sv =====
// Shared types, codes and widths for the ordered list range delete block.
package olrd_pkg;

    localparam int OP_W      = 2;
    localparam int POS_W     = 5;
    localparam int DATA_W    = 32;
    localparam int COUNT_W   = 5;
    localparam int DEPTH_DEF = 16;
    localparam int CQ_DEPTH  = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    typedef enum logic [1:0] {
        K_INSERT,
        K_DELETE,
        K_READ,
        K_REJECT
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
    } t_cmd;

endpackage

// ===== rtl/olrd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module olrd_ram #(
    parameter int W = 32,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/olrd_front.sv =====
// Front end: accepts input transactions, classifies them and queues commands.
module olrd_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [olrd_pkg::OP_W-1:0]        i_operation,
    input  logic [olrd_pkg::POS_W-1:0]       i_position,
    input  logic signed [olrd_pkg::DATA_W-1:0] i_value,
    input  logic signed [olrd_pkg::DATA_W-1:0] i_low_bound,
    input  logic signed [olrd_pkg::DATA_W-1:0] i_high_bound,
    output logic                             o_q_valid,
    output olrd_pkg::t_cmd                   o_q_cmd,
    input  logic                             i_q_take
);

    localparam int QAW = (olrd_pkg::CQ_DEPTH > 1) ? $clog2(olrd_pkg::CQ_DEPTH) : 1;
    localparam int QFW = $clog2(olrd_pkg::CQ_DEPTH + 1);

    olrd_pkg::t_cmd r_q [olrd_pkg::CQ_DEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QFW-1:0] r_fill;
    olrd_pkg::t_cmd cmd;
    logic           do_push;
    logic           do_take;

    always_comb begin
        cmd.pos   = i_position;
        cmd.value = i_value;
        cmd.lo    = i_low_bound;
        cmd.hi    = i_high_bound;
        case (i_operation)
            olrd_pkg::OP_INSERT: begin
                cmd.kind = (i_position != '0) ? olrd_pkg::K_INSERT : olrd_pkg::K_REJECT;
            end
            olrd_pkg::OP_DELETE: begin
                cmd.kind = (i_low_bound < i_high_bound) ? olrd_pkg::K_DELETE
                                                        : olrd_pkg::K_REJECT;
            end
            olrd_pkg::OP_READ: begin
                cmd.kind = (i_position != '0) ? olrd_pkg::K_READ : olrd_pkg::K_REJECT;
            end
            default: begin
                cmd.kind = olrd_pkg::K_REJECT;
            end
        endcase
    end

    assign full      = (r_fill == QFW'(olrd_pkg::CQ_DEPTH));
    assign o_q_valid = (r_fill != '0);
    assign o_q_cmd   = r_q[r_rp];
    assign do_push   = push && !full;
    assign do_take   = o_q_valid && i_q_take;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= cmd;
        end
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QAW'(olrd_pkg::CQ_DEPTH - 1)) ? '0 : r_wp + QAW'(1);
            end
            if (do_take) begin
                r_rp <= (r_rp == QAW'(olrd_pkg::CQ_DEPTH - 1)) ? '0 : r_rp + QAW'(1);
            end
            if (do_push && !do_take) begin
                r_fill <= r_fill + QFW'(1);
            end else if (!do_push && do_take) begin
                r_fill <= r_fill - QFW'(1);
            end
        end
    end

endmodule

// ===== rtl/olrd_back.sv =====
// Back end: sequences inserts, range deletes and reads over the entry RAM.
module olrd_back #(
    parameter int DEPTH = olrd_pkg::DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    input  olrd_pkg::t_cmd                     i_q_cmd,
    output logic                               o_q_take,
    input  logic                               pop,
    output logic                               empty,
    output logic                               o_ok,
    output logic signed [olrd_pkg::DATA_W-1:0] o_read_value,
    output logic [olrd_pkg::COUNT_W-1:0]       o_count,
    output logic                               o_ram_we,
    output logic [$clog2(DEPTH)-1:0]           o_ram_waddr,
    output logic [olrd_pkg::DATA_W-1:0]        o_ram_wdata,
    output logic [$clog2(DEPTH)-1:0]           o_ram_raddr,
    input  logic signed [olrd_pkg::DATA_W-1:0] i_ram_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > olrd_pkg::POS_W) ? CW : olrd_pkg::POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_RD_WAIT,
        S_SCAN,
        S_COMP
    } t_state;

    t_state                       r_state, n_state;
    logic [CW-1:0]                r_cnt, n_cnt;
    logic [CW-1:0]                r_i, n_i;
    logic                         r_dv, n_dv;
    logic [AW-1:0]                r_dj, n_dj;
    logic                         r_run, n_run;
    logic [CW-1:0]                r_f, n_f;
    logic [CW-1:0]                r_n, n_n;
    olrd_pkg::t_cmd               r_cmd, n_cmd;
    logic                         r_res_valid, n_res_valid;
    logic                         r_ok, n_ok;
    logic signed [olrd_pkg::DATA_W-1:0] r_rd, n_rd;
    logic                         s_run;
    logic [CW-1:0]                s_first;

    assign empty        = !r_res_valid;
    assign o_ok         = r_ok;
    assign o_read_value = r_rd;
    assign o_count      = olrd_pkg::COUNT_W'(r_cnt);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_i         = r_i;
        n_dv        = 1'b0;
        n_dj        = r_dj;
        n_run       = r_run;
        n_f         = r_f;
        n_n         = r_n;
        n_cmd       = r_cmd;
        n_res_valid = r_res_valid;
        n_ok        = r_ok;
        n_rd        = r_rd;
        s_run       = r_run;
        s_first     = r_f;
        o_q_take    = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = '0;
        o_ram_wdata = r_cmd.value;
        o_ram_raddr = '0;

        if (r_res_valid && pop) begin
            n_res_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_q_valid && !r_res_valid) begin
                    o_q_take = 1'b1;
                    n_cmd    = i_q_cmd;
                    n_ok     = 1'b0;
                    n_rd     = '0;
                    case (i_q_cmd.kind)
                        olrd_pkg::K_INSERT: begin
                            if ((XW'(i_q_cmd.pos) - XW'(1) > XW'(r_cnt)) ||
                                (r_cnt >= CW'(DEPTH))) begin
                                n_res_valid = 1'b1;
                            end else begin
                                n_i     = r_cnt;
                                n_state = S_INS_RD;
                            end
                        end
                        olrd_pkg::K_DELETE: begin
                            if (r_cnt == '0) begin
                                n_res_valid = 1'b1;
                            end else begin
                                n_i     = '0;
                                n_run   = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        olrd_pkg::K_READ: begin
                            if (XW'(i_q_cmd.pos) > XW'(r_cnt)) begin
                                n_res_valid = 1'b1;
                            end else begin
                                o_ram_raddr = AW'(XW'(i_q_cmd.pos) - XW'(1));
                                n_state     = S_RD_WAIT;
                            end
                        end
                        default: begin
                            n_res_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                if (XW'(r_i) >= XW'(r_cmd.pos)) begin
                    o_ram_raddr = AW'(r_i - CW'(1));
                    n_state     = S_INS_WR;
                end else begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = AW'(XW'(r_cmd.pos) - XW'(1));
                    o_ram_wdata = r_cmd.value;
                    n_cnt       = r_cnt + CW'(1);
                    n_res_valid = 1'b1;
                    n_ok        = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_INS_WR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = AW'(r_i);
                o_ram_wdata = i_ram_rdata;
                n_i         = r_i - CW'(1);
                n_state     = S_INS_RD;
            end
            S_RD_WAIT: begin
                n_res_valid = 1'b1;
                n_ok        = 1'b1;
                n_rd        = i_ram_rdata;
                n_state     = S_IDLE;
            end
            S_SCAN: begin
                if (r_i < r_cnt) begin
                    o_ram_raddr = AW'(r_i);
                    n_dv        = 1'b1;
                    n_dj        = AW'(r_i);
                    n_i         = r_i + CW'(1);
                end
                if (r_dv) begin
                    if (!r_run && (i_ram_rdata >= r_cmd.lo)) begin
                        s_run   = 1'b1;
                        s_first = CW'(r_dj);
                    end
                    if (s_run && (i_ram_rdata > r_cmd.hi)) begin
                        n_f     = s_first;
                        n_n     = CW'(r_dj);
                        n_dv    = 1'b0;
                        n_state = S_COMP;
                    end else if (CW'(r_dj) == r_cnt - CW'(1)) begin
                        n_dv = 1'b0;
                        if (!s_run) begin
                            n_res_valid = 1'b1;
                            n_state     = S_IDLE;
                        end else begin
                            n_f     = s_first;
                            n_n     = r_cnt;
                            n_state = S_COMP;
                        end
                    end else begin
                        n_run = s_run;
                        n_f   = s_first;
                    end
                end
            end
            S_COMP: begin
                if (r_n < r_cnt) begin
                    o_ram_raddr = AW'(r_n);
                    n_dv        = 1'b1;
                    n_n         = r_n + CW'(1);
                end
                if (r_dv) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = AW'(r_f);
                    o_ram_wdata = i_ram_rdata;
                    n_f         = r_f + CW'(1);
                end
                if ((r_n >= r_cnt) && !r_dv) begin
                    n_cnt       = r_f;
                    n_res_valid = 1'b1;
                    n_ok        = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_i   <= n_i;
        r_dj  <= n_dj;
        r_run <= n_run;
        r_f   <= n_f;
        r_n   <= n_n;
        r_cmd <= n_cmd;
        r_ok  <= n_ok;
        r_rd  <= n_rd;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_dv        <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_dv        <= n_dv;
            r_res_valid <= n_res_valid;
        end
    end

endmodule

// ===== rtl/ordered_list_range_delete.sv =====
// Top level: ordered list with positional insert, range delete and read.
// Throughput: one transaction at a time in the back end, set by the entry RAM's
// single read and write port; a two-entry command queue keeps accepting meanwhile.
// Reset (synchronous, active low) empties the list, the command queue and the held
// result; entry storage is not cleared.
module ordered_list_range_delete #(
    parameter int DEPTH = olrd_pkg::DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [olrd_pkg::OP_W-1:0]          i_operation,
    input  logic [olrd_pkg::POS_W-1:0]         i_position,
    input  logic signed [olrd_pkg::DATA_W-1:0] i_value,
    input  logic signed [olrd_pkg::DATA_W-1:0] i_low_bound,
    input  logic signed [olrd_pkg::DATA_W-1:0] i_high_bound,
    output logic                               empty,
    input  logic                               pop,
    output logic                               o_ok,
    output logic signed [olrd_pkg::DATA_W-1:0] o_read_value,
    output logic [olrd_pkg::COUNT_W-1:0]       o_count
);

    localparam int AW = $clog2(DEPTH);

    logic                        q_valid;
    olrd_pkg::t_cmd              q_cmd;
    logic                        q_take;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [olrd_pkg::DATA_W-1:0] ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [olrd_pkg::DATA_W-1:0] ram_rdata;

    olrd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_operation  (i_operation),
        .i_position   (i_position),
        .i_value      (i_value),
        .i_low_bound  (i_low_bound),
        .i_high_bound (i_high_bound),
        .o_q_valid    (q_valid),
        .o_q_cmd      (q_cmd),
        .i_q_take     (q_take)
    );

    olrd_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_cmd      (q_cmd),
        .o_q_take     (q_take),
        .pop          (pop),
        .empty        (empty),
        .o_ok         (o_ok),
        .o_read_value (o_read_value),
        .o_count      (o_count),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata),
        .o_ram_raddr  (ram_raddr),
        .i_ram_rdata  (ram_rdata)
    );

    olrd_ram #(
        .W (olrd_pkg::DATA_W),
        .D (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

// ===== tb/sv/olrd_checker.sv =====
// Checker for the ordered list block: tracks the list, predicts every reply and compares it.
`timescale 1ns / 100ps

module olrd_checker #(
    parameter int DEPTH = olrd_pkg::DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    input  logic                               full,
    input  logic [olrd_pkg::OP_W-1:0]          i_operation,
    input  logic [olrd_pkg::POS_W-1:0]         i_position,
    input  logic signed [olrd_pkg::DATA_W-1:0] i_value,
    input  logic signed [olrd_pkg::DATA_W-1:0] i_low_bound,
    input  logic signed [olrd_pkg::DATA_W-1:0] i_high_bound,
    input  logic                               empty,
    input  logic                               pop,
    input  logic                               i_ok,
    input  logic signed [olrd_pkg::DATA_W-1:0] i_read_value,
    input  logic [olrd_pkg::COUNT_W-1:0]       i_count,
    output int                                 o_errors,
    output int                                 o_pending,
    output int                                 o_held
);
    import olrd_pkg::*;

    typedef struct {
        logic                     ok;
        logic signed [DATA_W-1:0] read_value;
        logic [COUNT_W-1:0]       count;
    } t_reply;

    logic signed [DATA_W-1:0] list_entries [DEPTH];
    int                       list_count;
    t_reply                   pending_replies [$];

    function automatic t_reply list_apply(
        input logic [OP_W-1:0]          op,
        input logic [POS_W-1:0]         pos,
        input logic signed [DATA_W-1:0] val,
        input logic signed [DATA_W-1:0] lo,
        input logic signed [DATA_W-1:0] hi
    );
        t_reply r;
        int     p;
        int     k;
        int     first;
        int     next;
        r.ok = 1'b0;
        r.read_value = '0;
        p = int'(pos);
        case (op)
            OP_INSERT: begin
                if (p >= 1 && p <= list_count + 1 && list_count < DEPTH) begin
                    for (k = list_count; k >= p; k--)
                        list_entries[k] = list_entries[k-1];
                    list_entries[p-1] = val;
                    list_count++;
                    r.ok = 1'b1;
                end
            end
            OP_DELETE: begin
                if (lo < hi && list_count != 0) begin
                    first = 0;
                    while (first < list_count && list_entries[first] < lo)
                        first++;
                    if (first < list_count) begin
                        next = first;
                        while (next < list_count && list_entries[next] <= hi)
                            next++;
                        while (next < list_count) begin
                            list_entries[first] = list_entries[next];
                            first++;
                            next++;
                        end
                        list_count = first;
                        r.ok = 1'b1;
                    end
                end
            end
            OP_READ: begin
                if (p >= 1 && p <= list_count) begin
                    r.read_value = list_entries[p-1];
                    r.ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.count = list_count[COUNT_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            list_count = 0;
            pending_replies.delete();
            o_errors = 0;
        end else begin
            if (pop && !empty) begin
                if (pending_replies.size() == 0) begin
                    $display("%0t: unexpected reply ok %0d read_value %0d count %0d",
                             $time, i_ok, i_read_value, i_count);
                    o_errors++;
                end else begin
                    want = pending_replies.pop_front();
                    if (i_ok !== want.ok) begin
                        $display("%0t: ok expected %0d actual %0d", $time, want.ok, i_ok);
                        o_errors++;
                    end
                    if (i_read_value !== want.read_value) begin
                        $display("%0t: read_value expected %0d actual %0d",
                                 $time, want.read_value, i_read_value);
                        o_errors++;
                    end
                    if (i_count !== want.count) begin
                        $display("%0t: count expected %0d actual %0d",
                                 $time, want.count, i_count);
                        o_errors++;
                    end
                end
            end
            if (push && !full)
                pending_replies.push_back(list_apply(i_operation, i_position, i_value,
                                                     i_low_bound, i_high_bound));
        end
        o_pending = pending_replies.size();
        o_held = list_count;
    end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top: drives commands and drains replies of the ordered list block.
`timescale 1ns / 100ps

module tb;
    import olrd_pkg::*;

    localparam int              ITEMS    = 1700;
    localparam int              DEPTH    = DEPTH_DEF;
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     push;
    logic                     full;
    logic [OP_W-1:0]          i_operation;
    logic [POS_W-1:0]         i_position;
    logic signed [DATA_W-1:0] i_value;
    logic signed [DATA_W-1:0] i_low_bound;
    logic signed [DATA_W-1:0] i_high_bound;
    logic                     empty;
    logic                     pop;
    logic                     o_ok;
    logic signed [DATA_W-1:0] o_read_value;
    logic [COUNT_W-1:0]       o_count;
    int                       errors;
    int                       pending;
    int                       held;
    logic                     long_hold_req;

    ordered_list_range_delete #(.DEPTH(DEPTH)) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_operation  (i_operation),
        .i_position   (i_position),
        .i_value      (i_value),
        .i_low_bound  (i_low_bound),
        .i_high_bound (i_high_bound),
        .empty        (empty),
        .pop          (pop),
        .o_ok         (o_ok),
        .o_read_value (o_read_value),
        .o_count      (o_count)
    );

    olrd_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_operation  (i_operation),
        .i_position   (i_position),
        .i_value      (i_value),
        .i_low_bound  (i_low_bound),
        .i_high_bound (i_high_bound),
        .empty        (empty),
        .pop          (pop),
        .i_ok         (o_ok),
        .i_read_value (o_read_value),
        .i_count      (o_count),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_held       (held)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("tb: errors");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return int'($urandom_range(0, 200)) - 100;
        else if (r < 90)
            return $urandom;
        case ($urandom_range(0, 3))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return 0;
            default: return -1;
        endcase
    endfunction

    task automatic send_item(
        input logic [OP_W-1:0]          op,
        input logic [POS_W-1:0]         pos,
        input logic signed [DATA_W-1:0] val,
        input logic signed [DATA_W-1:0] lo,
        input logic signed [DATA_W-1:0] hi
    );
        push         <= 1'b1;
        i_operation  <= op;
        i_position   <= pos;
        i_value      <= val;
        i_low_bound  <= lo;
        i_high_bound <= hi;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
    endtask

    task automatic hold_push(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (cycles - 1)
                @(negedge i_clk);
        end
    endtask

    task automatic directed(
        input logic [OP_W-1:0]          op,
        input logic [POS_W-1:0]         pos,
        input logic signed [DATA_W-1:0] val,
        input logic signed [DATA_W-1:0] lo,
        input logic signed [DATA_W-1:0] hi
    );
        @(negedge i_clk);
        send_item(op, pos, val, lo, hi);
        hold_push(pick_gap());
    endtask

    initial begin : result_drain
        int stall;
        int drained;
        drained = 0;
        @(posedge i_rst_n);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall = 300;
            end else if (drained % 300 < 40) begin
                stall = 0;
            end else begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                @(negedge i_clk);
                pop <= 1'b0;
                repeat (stall - 1)
                    @(negedge i_clk);
            end
            @(negedge i_clk);
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty)
                @(posedge i_clk);
            drained++;
        end
    end

    initial begin : stimulus
        int                       sent;
        int                       i;
        int                       r;
        int                       seq_len;
        int                       w_insert;
        int                       gap;
        int                       run_value;
        bit                       sorted_mode;
        bit                       pressure_done;
        logic [OP_W-1:0]          op;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;

        i_rst_n       = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        i_operation   = OP_INSERT;
        i_position    = '0;
        i_value       = '0;
        i_low_bound   = '0;
        i_high_bound  = '0;
        long_hold_req = 1'b0;
        pressure_done = 1'b0;
        repeat (3)
            @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty list, bad positions, extremes, unsorted content
        directed(OP_READ,   5'd1,  0, 0, 0);
        directed(OP_DELETE, 5'd0,  0, -5, 5);
        directed(OP_INSERT, 5'd0,  1, 0, 0);
        directed(OP_INSERT, 5'd2,  1, 0, 0);
        directed(OP_INSERT, 5'd1,  VAL_MAX, 0, 0);
        directed(OP_INSERT, 5'd1,  VAL_MIN, 0, 0);
        directed(OP_INSERT, 5'd3,  0, 0, 0);
        directed(OP_INSERT, 5'd31, 9, 0, 0);
        directed(OP_READ,   5'd31, 0, 0, 0);
        directed(OP_READ,   5'd3,  0, 0, 0);
        directed(OP_READ,   5'd2,  0, 0, 0);
        directed(OP_READ,   5'd4,  0, 0, 0);
        directed(OP_DELETE, 5'd0,  0, 5, 5);
        directed(OP_DELETE, 5'd0,  0, 10, 3);
        directed(OP_DELETE, 5'd0,  0, VAL_MIN, -1);
        directed(OP_INSERT, 5'd3,  5, 0, 0);
        directed(OP_DELETE, 5'd31, 0, 1, 100);
        directed(OP_DELETE, 5'd0,  0, VAL_MAX - 1, VAL_MAX);
        directed(OP_INSERT, 5'd1,  7, 0, 0);
        directed(OP_INSERT, 5'd2,  -3, 0, 0);
        directed(OP_DELETE, 5'd0,  0, 8, 20);
        directed(OP_SPARE,  5'd1,  -1, -1, -1);
        sent = 22;

        while (sent < ITEMS) begin
            seq_len     = $urandom_range(40, 80);
            w_insert    = $urandom_range(20, 85);
            sorted_mode = ($urandom_range(0, 2) == 0);
            run_value   = int'($urandom_range(0, 100)) - 50;
            if (!pressure_done)
                long_hold_req = 1'b1;
            for (i = 0; i < seq_len && sent < ITEMS; i++) begin
                @(negedge i_clk);
                r   = $urandom_range(0, 99);
                pos = POS_W'($urandom_range(0, 31));
                val = pick_value();
                lo  = pick_value();
                hi  = ($urandom_range(0, 99) < 85) ? lo + $urandom_range(0, 80)
                                                   : pick_value();
                if (r < 1) begin
                    op = OP_SPARE;
                end else if (r < w_insert) begin
                    op = OP_INSERT;
                    if (sorted_mode) begin
                        run_value += $urandom_range(1, 20);
                        val = run_value;
                        if ($urandom_range(0, 9) != 0)
                            pos = POS_W'(held + 1);
                    end else if ($urandom_range(0, 9) != 0) begin
                        pos = POS_W'($urandom_range(1, held + 1));
                    end
                end else if (r < w_insert + (100 - w_insert) / 3) begin
                    op = OP_READ;
                    if ($urandom_range(0, 9) != 0)
                        pos = POS_W'($urandom_range(1, (held > 0) ? held : 1));
                end else begin
                    op = OP_DELETE;
                    if (sorted_mode && $urandom_range(0, 1) == 0) begin
                        lo = run_value - int'($urandom_range(0, 200));
                        hi = lo + $urandom_range(0, 60);
                    end
                end
                send_item(op, pos, val, lo, hi);
                sent++;
                if (sent == ITEMS / 2) begin
                    hold_push(1);
                    while (pending != 0)
                        @(negedge i_clk);
                end else begin
                    if (!pressure_done && i < 25)
                        gap = 0;
                    else if (sent % 250 < 30)
                        gap = 0;
                    else
                        gap = pick_gap();
                    hold_push(gap);
                end
            end
            pressure_done = 1'b1;
        end

        @(negedge i_clk);
        push <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (60)
            @(negedge i_clk);
        if (errors == 0 && pending == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
